@@ rtl/tcs_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcs_pkg: shared types and constants of the trim code search
// Register indexes, step direction codes, code map selectors and fold points.
// ----------------------------------------------------------------------------
package tcs_pkg;

	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TARGET     = 3'd0,
		REG_LOWER      = 3'd1,
		REG_UPPER      = 3'd2,
		REG_START_CODE = 3'd3,
		REG_SAVE_LIMIT = 3'd4,
		REG_CODE_MAP   = 3'd5
	} cfg_reg_t;

	typedef enum logic [1:0] {
		DIR_HOLD = 2'd0,
		DIR_UP   = 2'd1,
		DIR_DOWN = 2'd2
	} dir_t;

	typedef enum logic [1:0] {
		MAP_DIRECT  = 2'd0,
		MAP_FOLD8   = 2'd1,
		MAP_FOLD256 = 2'd2
	} map_t;

	localparam int COUNT_W = 8;
	localparam int MAP_W   = 2;

	// fold points and mirror tops of the two folded maps
	localparam int FOLD8_POINT   = 8;
	localparam int FOLD8_TOP     = 15;
	localparam int FOLD256_POINT = 256;
	localparam int FOLD256_TOP   = 511;

endpackage
`default_nettype wire

@@ rtl/tcs_code_map.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcs_code_map: trim code to register word mapping
// Direct, or folded around 8 (4-bit mirror) or 256 (9-bit mirror).
// ----------------------------------------------------------------------------
module tcs_code_map #(
	parameter int CODE_WIDTH = 10
) (
	input  logic [CODE_WIDTH-1:0]    code,
	input  logic [tcs_pkg::MAP_W-1:0] map_sel,
	output logic [CODE_WIDTH-1:0]    word
);
	import tcs_pkg::*;

	// wide enough for the fold constants and any code
	localparam int EW = ((CODE_WIDTH > 9) ? CODE_WIDTH : 9) + 1;

	logic [EW-1:0] code_ext;
	logic [EW-1:0] word_ext;

	assign code_ext = EW'(code);

	always_comb begin
		case (map_sel)
			MAP_FOLD8: begin
				if (code_ext < EW'(FOLD8_POINT)) begin
					word_ext = EW'(FOLD8_TOP) - code_ext;
				end else begin
					word_ext = code_ext - EW'(FOLD8_POINT);
				end
			end
			MAP_FOLD256: begin
				if (code_ext < EW'(FOLD256_POINT)) begin
					word_ext = EW'(FOLD256_TOP) - code_ext;
				end else begin
					word_ext = code_ext - EW'(FOLD256_POINT);
				end
			end
			default: begin
				word_ext = code_ext;
			end
		endcase
	end

	assign word = word_ext[CODE_WIDTH-1:0];

endmodule
`default_nettype wire

@@ rtl/trim_code_search.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trim_code_search: stepwise trim calibration search
// Steps a trim code toward a target measurement and reports the best code.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one measurement word per trial; m_* returns one result word
//   per measurement: next trial code (raw and mapped), in-range flag, step
//   direction, and on the final word of a search (m_tlast high) the best code
//   and its measurement.
//   cfg_* writes the registers by index; write only while the block is idle.
// Timing:
//   A measurement is registered on acceptance (meas_s1) and its result word is
//   then registered in the result register. One word per cycle is sustained
//   while m_tready stays high; the trial code, saved count and best entries are
//   updated on the same edge that loads the result register, so the next
//   measurement already sees them.
// Reset: registers return to their defaults, trial code to 16, no saved
//   samples, both pipeline stages empty.
// Stall: when m_tready is low the result word holds; an empty input stage
//   still takes one more word, then s_tready drops until the output drains.
// ----------------------------------------------------------------------------
module trim_code_search #(
	parameter int VALUE_WIDTH = 32,
	parameter int CODE_WIDTH  = 10
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// measurement stream
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [((VALUE_WIDTH+7)/8)*8-1:0]    s_tdata,  // measured
	// result stream
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// reg_word, trial_code_out, in_range, direction, best_value
	output logic [((2*CODE_WIDTH+3+VALUE_WIDTH+7)/8)*8-1:0] m_tdata,
	output logic                                m_tlast,  // done_res
	// register writes
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [tcs_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [VALUE_WIDTH-1:0]              cfg_data
);
	import tcs_pkg::*;

	localparam int OUT_W  = ((2*CODE_WIDTH+3+VALUE_WIDTH+7)/8)*8;
	localparam int OFF_TC = CODE_WIDTH;
	localparam int OFF_IR = 2*CODE_WIDTH;
	localparam int OFF_DR = 2*CODE_WIDTH+1;
	localparam int OFF_BV = 2*CODE_WIDTH+3;

	localparam logic [VALUE_WIDTH-1:0] TARGET_RST = VALUE_WIDTH'(91750);
	localparam logic [VALUE_WIDTH-1:0] LOWER_RST  = VALUE_WIDTH'(87163);
	localparam logic [VALUE_WIDTH-1:0] UPPER_RST  = VALUE_WIDTH'(96338);
	localparam logic [CODE_WIDTH-1:0]  START_RST  = CODE_WIDTH'(16);
	localparam logic [COUNT_W-1:0]     LIMIT_RST  = COUNT_W'(100);
	localparam logic [CODE_WIDTH-1:0]  CODE_MAX   = {CODE_WIDTH{1'b1}};

	// registers
	logic [VALUE_WIDTH-1:0] target_q;
	logic [VALUE_WIDTH-1:0] lower_q;
	logic [VALUE_WIDTH-1:0] upper_q;
	logic [CODE_WIDTH-1:0]  start_code_q;
	logic [COUNT_W-1:0]     save_limit_q;
	logic [MAP_W-1:0]       code_map_q;

	// search state
	logic [CODE_WIDTH-1:0]  trial_code_q;
	logic [COUNT_W-1:0]     saved_count_q;
	logic [VALUE_WIDTH-1:0] best_dist_q;
	logic [VALUE_WIDTH-1:0] best_meas_q;
	logic [CODE_WIDTH-1:0]  best_code_q;

	// pipeline
	logic                   valid_s1;
	logic [VALUE_WIDTH-1:0] meas_s1;
	logic                   out_valid_q;
	logic [OUT_W-1:0]       out_data_q;
	logic                   out_last_q;
	logic                   advance;

	// step logic
	logic                   below;
	logic                   above;
	logic                   inr;
	dir_t                   dir;
	logic [VALUE_WIDTH-1:0] delta;
	logic                   take_best;
	logic [VALUE_WIDTH-1:0] best_dist_n;
	logic [VALUE_WIDTH-1:0] best_meas_n;
	logic [CODE_WIDTH-1:0]  best_code_n;
	logic [COUNT_W-1:0]     count_inc;
	logic [COUNT_W-1:0]     limit;
	logic                   done;
	logic [CODE_WIDTH-1:0]  stepped_code;
	logic [CODE_WIDTH-1:0]  out_code;
	logic [CODE_WIDTH-1:0]  out_word;
	logic [OUT_W-1:0]       out_data_n;

	assign advance   = ~out_valid_q | m_tready;
	assign s_tready  = ~valid_s1 | advance;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_data_q;
	assign m_tlast   = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q     <= TARGET_RST;
			lower_q      <= LOWER_RST;
			upper_q      <= UPPER_RST;
			start_code_q <= START_RST;
			save_limit_q <= LIMIT_RST;
			code_map_q   <= MAP_DIRECT;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_TARGET:     target_q     <= cfg_data;
				REG_LOWER:      lower_q      <= cfg_data;
				REG_UPPER:      upper_q      <= cfg_data;
				REG_START_CODE: start_code_q <= cfg_data[CODE_WIDTH-1:0];
				REG_SAVE_LIMIT: save_limit_q <= cfg_data[COUNT_W-1:0];
				REG_CODE_MAP:   code_map_q   <= cfg_data[MAP_W-1:0];
				default: ;
			endcase
		end
	end

	// ---- compare, distance, best tracking ----
	always_comb begin
		below = meas_s1 < target_q;
		above = meas_s1 > target_q;
		if (below) begin
			inr   = meas_s1 >= lower_q;
			dir   = DIR_UP;
			delta = target_q - meas_s1;
		end else if (above) begin
			inr   = meas_s1 <= upper_q;
			dir   = DIR_DOWN;
			delta = meas_s1 - target_q;
		end else begin
			inr   = 1'b1;
			dir   = DIR_HOLD;
			delta = '0;
		end
	end

	// first saved sample always wins; ties keep the earlier one
	assign take_best   = inr & ((saved_count_q == '0) | (delta < best_dist_q));
	assign best_dist_n = take_best ? delta : best_dist_q;
	assign best_meas_n = take_best ? meas_s1 : best_meas_q;
	assign best_code_n = take_best ? trial_code_q : best_code_q;
	assign count_inc   = saved_count_q + COUNT_W'(inr);
	assign limit       = (save_limit_q == '0) ? COUNT_W'(1) : save_limit_q;
	assign done        = count_inc >= limit;

	always_comb begin
		case (dir)
			DIR_UP:   stepped_code = (trial_code_q == CODE_MAX) ? trial_code_q
			                                                    : trial_code_q + 1'b1;
			DIR_DOWN: stepped_code = (trial_code_q == '0) ? trial_code_q
			                                              : trial_code_q - 1'b1;
			default:  stepped_code = trial_code_q;
		endcase
	end

	assign out_code = done ? best_code_n : stepped_code;

	tcs_code_map #(
		.CODE_WIDTH(CODE_WIDTH)
	) u_map (
		.code    (out_code),
		.map_sel (code_map_q),
		.word    (out_word)
	);

	always_comb begin
		out_data_n = '0;
		out_data_n[CODE_WIDTH-1:0]              = out_word;
		out_data_n[OFF_TC +: CODE_WIDTH]        = out_code;
		out_data_n[OFF_IR]                      = inr;
		out_data_n[OFF_DR +: 2]                 = dir;
		out_data_n[OFF_BV +: VALUE_WIDTH]       = done ? best_meas_n : '0;
	end

	// ---- input stage ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			meas_s1 <= s_tdata[VALUE_WIDTH-1:0];
		end
	end

	// ---- result stage and search state ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q   <= 1'b0;
			out_last_q    <= 1'b0;
			trial_code_q  <= START_RST;
			saved_count_q <= '0;
			best_dist_q   <= '0;
			best_meas_q   <= '0;
			best_code_q   <= '0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				out_last_q  <= done;
				best_dist_q <= best_dist_n;
				best_meas_q <= best_meas_n;
				best_code_q <= best_code_n;
				if (done) begin
					trial_code_q  <= start_code_q;
					saved_count_q <= '0;
				end else begin
					trial_code_q  <= stepped_code;
					saved_count_q <= count_inc;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			out_data_q <= out_data_n;
		end
	end

endmodule
`default_nettype wire

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking regression of trim_code_search
// Streams measurement words through the search and checks every result word
// against an in-bench model of the trim stepping, the window test, the
// best-sample tracking and the three code maps. The run steps through a
// number of register settings, with bursty input and a stalling receiver.
// ----------------------------------------------------------------------------
module testbench;
	import tcs_pkg::*;

	localparam int VAL_W      = 32;
	localparam int CODE_W     = 10;
	localparam int RES_W      = 56;
	localparam int PERIOD_HI  = 4;
	localparam int PERIOD_LO  = 4;
	localparam int SETTLE     = 6;
	localparam int RUN_LIMIT  = 400000;
	localparam int RAND_PHASES = 8;
	localparam int PHASE_ITEMS = 200;
	localparam int MAX_PRINTS = 40;

	// result word layout, lowest bit up
	localparam int RW_LO  = 0;
	localparam int TC_LO  = RW_LO + CODE_W;
	localparam int IR_BIT = TC_LO + CODE_W;
	localparam int DIR_LO = IR_BIT + 1;
	localparam int BV_LO  = DIR_LO + 2;

	// selector value with no map of its own, acts as direct
	localparam logic [MAP_W-1:0] MAP_SPARE = 2'd3;

	typedef struct packed {
		logic [CODE_W-1:0] reg_word;
		logic [CODE_W-1:0] code;
		logic              win_hit;
		dir_t              dir;
		logic              done;
		logic [VAL_W-1:0]  best_value;
	} trim_result_t;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        s_tvalid = 1'b0;
	logic                        s_tready;
	logic [VAL_W-1:0]            s_tdata = '0;
	logic                        m_tvalid;
	logic                        m_tready = 1'b0;
	logic [RES_W-1:0]            m_tdata;
	logic                        m_tlast;
	logic                        cfg_valid = 1'b0;
	logic                        cfg_ready;
	logic [CFG_IDX_W-1:0]        cfg_index = REG_TARGET;
	logic [VAL_W-1:0]            cfg_data = '0;

	trim_code_search i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#PERIOD_HI clk = 1'b1;
		#PERIOD_LO clk = 1'b0;
	end

	// model registers and search state
	logic [VAL_W-1:0]   mdl_target = 32'd91750;
	logic [VAL_W-1:0]   mdl_lower  = 32'd87163;
	logic [VAL_W-1:0]   mdl_upper  = 32'd96338;
	logic [CODE_W-1:0]  mdl_start  = 10'd16;
	logic [COUNT_W-1:0] mdl_limit  = 8'd100;
	logic [MAP_W-1:0]   mdl_map    = MAP_DIRECT;
	logic [CODE_W-1:0]  trial      = 10'd16;
	logic [COUNT_W-1:0] saved      = '0;
	logic [VAL_W-1:0]   best_dist  = '0;
	logic [VAL_W-1:0]   best_meas  = '0;
	logic [CODE_W-1:0]  best_code  = '0;

	logic [VAL_W-1:0] meas_q[$];
	trim_result_t     pending_results[$];
	trim_result_t     want;

	int  sent_cnt = 0;
	int  acc_cnt = 0;
	int  word_cnt = 0;
	int  errors = 0;
	int  cyc = 0;
	int  done_cnt = 0;
	int  inr_cnt = 0;
	int  top_pins = 0;
	int  bottom_pins = 0;
	int  settings_cnt = 0;
	logic in_fire = 1'b0;
	logic cfg_fire = 1'b0;

	// one measurement through the search; updates the model state
	function automatic trim_result_t search_step(logic [VAL_W-1:0] meas);
		trim_result_t       r;
		logic [VAL_W-1:0]   delta;
		logic [COUNT_W-1:0] lim;
		r = '0;
		lim = (mdl_limit == 0) ? 8'd1 : mdl_limit;
		if (meas < mdl_target) begin
			r.win_hit = (meas >= mdl_lower);
			r.dir = DIR_UP;
			delta = mdl_target - meas;
		end else if (meas > mdl_target) begin
			r.win_hit = (meas <= mdl_upper);
			r.dir = DIR_DOWN;
			delta = meas - mdl_target;
		end else begin
			r.win_hit = 1'b1;
			r.dir = DIR_HOLD;
			delta = '0;
		end
		if (r.win_hit) begin
			// first sample of a search always wins; ties keep the older one
			if (saved == 0 || delta < best_dist) begin
				best_dist = delta;
				best_meas = meas;
				best_code = trial;
			end
			saved = saved + 1'b1;
		end
		if (r.dir == DIR_UP) begin
			if (trial != '1)
				trial = trial + 1'b1;
			else
				top_pins++;
		end else if (r.dir == DIR_DOWN) begin
			if (trial != '0)
				trial = trial - 1'b1;
			else
				bottom_pins++;
		end
		if (saved >= lim) begin
			r.code = best_code;
			r.done = 1'b1;
			r.best_value = best_meas;
			trial = mdl_start;
			saved = '0;
		end else begin
			r.code = trial;
		end
		if (mdl_map == MAP_FOLD8)
			r.reg_word = (r.code < FOLD8_POINT) ? CODE_W'(FOLD8_TOP - r.code)
				: CODE_W'(r.code - FOLD8_POINT);
		else if (mdl_map == MAP_FOLD256)
			r.reg_word = (r.code < FOLD256_POINT) ? CODE_W'(FOLD256_TOP - r.code)
				: CODE_W'(r.code - FOLD256_POINT);
		else
			r.reg_word = r.code;
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] exp_v);
		errors++;
		if (errors <= MAX_PRINTS)
			$display("word %0d: %s got %0h, want %0h", word_cnt, what, got, exp_v);
	endtask

	// monitor: check results, track config writes, predict accepted words
	always @(posedge clk) begin
		cyc <= cyc + 1;
		in_fire <= s_tvalid && s_tready;
		cfg_fire <= cfg_valid && cfg_ready;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (pending_results.size() == 0) begin
					report_mismatch("word with nothing pending", m_tdata, '0);
				end else begin
					want = pending_results.pop_front();
					if (m_tdata[RW_LO +: CODE_W] !== want.reg_word)
						report_mismatch("reg_word", m_tdata[RW_LO +: CODE_W], want.reg_word);
					if (m_tdata[TC_LO +: CODE_W] !== want.code)
						report_mismatch("trial_code_out", m_tdata[TC_LO +: CODE_W], want.code);
					if (m_tdata[IR_BIT] !== want.win_hit)
						report_mismatch("window flag", m_tdata[IR_BIT], want.win_hit);
					if (m_tdata[DIR_LO +: 2] !== want.dir)
						report_mismatch("direction", m_tdata[DIR_LO +: 2], want.dir);
					if (m_tlast !== want.done)
						report_mismatch("done_res", m_tlast, want.done);
					if (m_tdata[BV_LO +: VAL_W] !== want.best_value)
						report_mismatch("best_value", m_tdata[BV_LO +: VAL_W], want.best_value);
				end
				word_cnt <= word_cnt + 1;
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_TARGET:     mdl_target = cfg_data;
					REG_LOWER:      mdl_lower = cfg_data;
					REG_UPPER:      mdl_upper = cfg_data;
					REG_START_CODE: mdl_start = cfg_data[CODE_W-1:0];
					REG_SAVE_LIMIT: mdl_limit = cfg_data[COUNT_W-1:0];
					REG_CODE_MAP:   mdl_map = cfg_data[MAP_W-1:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				want = search_step(s_tdata);
				pending_results.push_back(want);
				acc_cnt <= acc_cnt + 1;
				if (want.done)
					done_cnt <= done_cnt + 1;
				if (want.win_hit)
					inr_cnt <= inr_cnt + 1;
			end
		end
	end

	// measurement driver: bursts with random gaps
	int burst_left = 1;
	int gap_left = 0;

	always @(negedge clk) begin
		if (arst_n && (!s_tvalid || in_fire)) begin
			if (gap_left != 0) begin
				gap_left <= gap_left - 1;
				s_tvalid <= 1'b0;
			end else if (meas_q.size() != 0) begin
				s_tdata <= meas_q.pop_front();
				s_tvalid <= 1'b1;
				if (burst_left <= 1) begin
					burst_left <= ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
						: $urandom_range(1, 12);
					gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// result receiver: stall pattern switches at random among four modes
	int rx_mode = 0;
	int rx_left = 0;

	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_mode <= $urandom_range(0, 3);
			rx_left <= $urandom_range(50, 300);
		end else begin
			rx_left <= rx_left - 1;
		end
		case (rx_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= ($urandom_range(0, 3) != 0);
			2: m_tready <= ((cyc % 7) >= 3);
			default: m_tready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	task automatic push_meas(logic [VAL_W-1:0] v);
		meas_q.push_back(v);
		sent_cnt++;
	endtask

	// wait until every word is in and every result is out, then let it settle
	task automatic drain();
		while (acc_cnt != sent_cnt || pending_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	// caller is at a falling edge; cfg_valid stays high between writes
	task automatic cfg_put(cfg_reg_t idx, logic [VAL_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do
			@(negedge clk);
		while (!cfg_fire);
	endtask

	task automatic set_search(logic [VAL_W-1:0] tgt, logic [VAL_W-1:0] lo,
			logic [VAL_W-1:0] hi, logic [CODE_W-1:0] start,
			logic [COUNT_W-1:0] lim, logic [MAP_W-1:0] map);
		@(negedge clk);
		cfg_put(REG_TARGET, tgt);
		cfg_put(REG_LOWER, lo);
		cfg_put(REG_UPPER, hi);
		cfg_put(REG_START_CODE, VAL_W'(start));
		cfg_put(REG_SAVE_LIMIT, VAL_W'(lim));
		cfg_put(REG_CODE_MAP, VAL_W'(map));
		cfg_valid <= 1'b0;
		settings_cnt++;
	endtask

	// random measurement, weighted toward the window and its edges
	function automatic logic [VAL_W-1:0] pick_meas(logic [VAL_W-1:0] tgt,
			logic [VAL_W-1:0] lo, logic [VAL_W-1:0] hi);
		logic [63:0] span;
		int          kind;
		kind = $urandom_range(0, 11);
		span = {32'd0, hi} - {32'd0, lo} + 64'd1;
		case (kind)
			0, 1: return $urandom;
			2: return tgt;
			3: return lo;
			4: return hi;
			5: return lo - 1'b1;
			6: return hi + 1'b1;
			7, 8: return tgt + VAL_W'($urandom_range(0, 8)) - VAL_W'(4);
			default: begin
				if (lo <= hi)
					return VAL_W'({32'd0, lo} + ({32'd0, $urandom} % span));
				return $urandom;
			end
		endcase
	endfunction

	logic [VAL_W-1:0]   ph_tgt, ph_lo, ph_hi;
	logic [CODE_W-1:0]  ph_start;
	logic [COUNT_W-1:0] ph_lim;
	logic [MAP_W-1:0]   ph_map;

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// register defaults: field extremes, window edges, hold, tie
		push_meas('0);
		push_meas('1);
		push_meas(32'd91750);
		push_meas(32'd87163);
		push_meas(32'd87162);
		push_meas(32'd96338);
		push_meas(32'd96339);
		push_meas(32'd91749);
		push_meas(32'd91751);
		push_meas(32'd91750);
		drain();

		// top of code range, tie keeps older sample, search completes
		set_search(32'd1000, 32'd900, 32'd1100, 10'd1022, 8'd4, MAP_FOLD8);
		push_meas(32'd950);
		push_meas(32'd990);
		push_meas(32'd1010);
		push_meas(32'd2000);
		push_meas(32'd1000);
		push_meas(32'd800);
		drain();

		// bottom of code range, save limit of zero, spare map selector
		set_search(32'd1000, 32'd900, 32'd1100, 10'd1, 8'd0, MAP_SPARE);
		push_meas(32'd1100);
		push_meas(32'd1101);
		push_meas(32'd1101);
		push_meas(32'd900);
		drain();

		// across the fold point of the wide map
		set_search(32'd5, 32'd0, 32'd10, 10'd255, 8'd2, MAP_FOLD256);
		push_meas(32'd3);
		push_meas(32'd5);
		drain();

		for (int p = 0; p < RAND_PHASES; p++) begin
			ph_tgt = $urandom;
			ph_lo = ph_tgt - VAL_W'($urandom_range(0, 5000));
			ph_hi = ph_tgt + VAL_W'($urandom_range(0, 5000));
			ph_start = CODE_W'($urandom_range(0, 1023));
			ph_lim = COUNT_W'($urandom_range(1, 12));
			ph_map = MAP_W'($urandom_range(0, 3));
			case (p)
				0: begin
					ph_tgt = '0; ph_lo = '0; ph_hi = '1;
					ph_start = '0; ph_lim = 8'd1; ph_map = MAP_DIRECT;
				end
				1: begin
					ph_tgt = '1; ph_lo = '0; ph_hi = '1;
					ph_start = '1; ph_lim = 8'd255; ph_map = MAP_FOLD256;
				end
				2: begin
					ph_lim = 8'd0;
					ph_map = MAP_SPARE;
				end
				3: begin
					ph_start = CODE_W'($urandom_range(0, 15));
					ph_map = MAP_FOLD8;
				end
				4: begin
					ph_start = CODE_W'($urandom_range(240, 270));
					ph_map = MAP_FOLD256;
				end
				default: ;
			endcase
			set_search(ph_tgt, ph_lo, ph_hi, ph_start, ph_lim, ph_map);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				push_meas(pick_meas(ph_tgt, ph_lo, ph_hi));
				// sender holds off mid-phase until the output is empty
				if (p == 2 && i == PHASE_ITEMS / 2)
					drain();
			end
			drain();
		end

		$display("%0d result words checked over %0d register settings, %0d searches done",
			word_cnt, settings_cnt, done_cnt);
		$display("%0d words in range; code held at bottom %0d and at top %0d times",
			inr_cnt, bottom_pins, top_pins);
		if (errors == 0)
			$display("trim_code_search regression: pass");
		else
			$display("trim_code_search regression: fail");
		$finish;
	end

	initial begin
		while (cyc < RUN_LIMIT)
			@(posedge clk);
		$display("trim_code_search regression: fail");
		$finish;
	end

endmodule
